FILE: rtl/rope_pkg.sv
// shared constants and float helpers for the bf16 pair rotator
package rope_pkg;

  localparam int unsigned MaxPositions = 256;
  localparam int unsigned MaxPairs     = 64;

  localparam logic [0:0] ReqLoad   = 1'b0;
  localparam logic [0:0] ReqRotate = 1'b1;

  localparam logic [0:0] StatusDone     = 1'b0;
  localparam logic [0:0] StatusBadIndex = 1'b1;

  localparam logic [0:0] RegSeqInUse   = 1'b0;
  localparam logic [0:0] RegPairsInUse = 1'b1;

  localparam logic [31:0] F32QNan  = 32'h7FC0_0000;
  localparam logic [15:0] Bf16QNan = 16'h7FC0;

  // unpacked f32: sign, unbiased-ish exponent, significand with hidden bit
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;   // exponent of bit 23 of mant
    logic [23:0] mant;
  } funp_t;

  function automatic funp_t f32_unpack(input logic [31:0] b);
    funp_t u;
    u.sign    = b[31];
    u.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    u.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.is_zero = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      u.exp  = 11'sd1 - 11'sd127;
      u.mant = {1'b0, b[22:0]};
    end else begin
      u.exp  = $signed({3'b000, b[30:23]}) - 11'sd127;
      u.mant = {1'b1, b[22:0]};
    end
    return u;
  endfunction

  // round a value sig * 2^(e-48) to f32, rne; sig top bit may be anywhere
  // sig is 50 bits, value = sig * 2^(e - 48); sticky folded into sig[0]
  function automatic logic [31:0] f32_round(input logic sign, input logic signed [11:0] e,
                                            input logic [49:0] sig);
    logic [5:0]  lz;
    logic [49:0] n;
    logic signed [12:0] ex;
    logic [6:0]  sh;
    logic [49:0] d;
    logic        st;
    logic [24:0] m;
    logic        g, r;
    logic [31:0] res;
    lz = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (sig[i]) lz = 6'(49 - i);
    end
    n  = sig << lz;
    // value = n * 2^(ex - 49), leading bit at 49 means value in [2^ex, 2^(ex+1))
    ex = 13'(e) + 13'sd1 - 13'($signed({1'b0, lz}));
    if (ex < -13'sd126) begin
      sh = (ex < -13'sd200) ? 7'd60 : 7'(-13'sd126 - ex);
      st = 1'b0;
      for (int i = 0; i < 50; i++) begin
        if (i < 7'(sh)) st = st | n[i];
      end
      d  = (sh >= 7'd50) ? 50'd0 : (n >> sh);
      d[0] = d[0] | st;
      ex = -13'sd126;
    end else begin
      d = n;
    end
    // d[49:26] = 24-bit significand, d[25] guard, rest sticky
    g  = d[25];
    r  = |d[24:0];
    m  = {1'b0, d[49:26]};
    if (g && (r || m[0])) m = m + 25'd1;
    if (m[24]) begin
      m  = m >> 1;
      ex = ex + 13'sd1;
    end
    if (sig == 50'd0) begin
      res = {sign, 31'd0};
    end else if (ex > 13'sd127) begin
      res = {sign, 8'hFF, 23'd0};
    end else if (!m[23]) begin
      res = {sign, 8'd0, m[22:0]};
    end else begin
      res = {sign, 8'(ex + 13'sd127), m[22:0]};
    end
    return res;
  endfunction

  function automatic logic [15:0] bf16_narrow(input logic [31:0] b);
    logic [31:0] s;
    if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) begin
      return Bf16QNan;
    end
    s = b + 32'h0000_7FFF + {31'd0, b[16]};
    return s[31:16];
  endfunction

endpackage

FILE: rtl/rope_ram.sv
// generic single-port-write, one-read ram with registered read
module rope_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/rope_fmul.sv
// f32 multiply: full product registered, then rounded combinationally at the output
module rope_fmul
  import rope_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  funp_t ua, ub;
  logic [47:0] prod_d, prod_q;
  logic signed [11:0] exp_d, exp_q;
  logic sign_q, nan_q, inf_q, zero_q;

  assign ua = f32_unpack(a_i);
  assign ub = f32_unpack(b_i);
  assign prod_d = ua.mant * ub.mant;
  assign exp_d  = 12'(ua.exp) + 12'(ub.exp);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      exp_q  <= exp_d;
      sign_q <= ua.sign ^ ub.sign;
      nan_q  <= ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
                (ub.is_inf && ua.is_zero);
      inf_q  <= ua.is_inf || ub.is_inf;
      zero_q <= ua.is_zero || ub.is_zero;
    end
  end

  // product value = prod * 2^(ea+eb-46) = {prod,2'b0} * 2^(exp-48)
  always_comb begin
    if (nan_q) begin
      p_o = F32QNan;
    end else if (inf_q) begin
      p_o = {sign_q, 8'hFF, 23'd0};
    end else if (zero_q) begin
      p_o = {sign_q, 31'd0};
    end else begin
      p_o = f32_round(sign_q, exp_q, {prod_q, 2'b00});
    end
  end

endmodule

FILE: rtl/rope_fadd.sv
// f32 add, combinational; caller registers the result
module rope_fadd
  import rope_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  funp_t ua, ub, big, lil;
  logic [7:0]  dexp;
  logic [49:0] mb, ml, sum;
  logic        st, rsign;

  assign ua = f32_unpack(a_i);
  assign ub = f32_unpack(b_i);

  always_comb begin
    if ((ua.exp > ub.exp) || ((ua.exp == ub.exp) && (ua.mant >= ub.mant))) begin
      big = ua;
      lil = ub;
    end else begin
      big = ub;
      lil = ua;
    end
    dexp = (big.exp - lil.exp > 11'sd60) ? 8'd60 : 8'(big.exp - lil.exp);
    mb   = {2'b00, big.mant, 24'd0};
    ml   = {2'b00, lil.mant, 24'd0};
    st   = 1'b0;
    for (int i = 0; i < 50; i++) begin
      if (i < dexp) st = st | ml[i];
    end
    ml   = (dexp >= 8'd50) ? 50'd0 : (ml >> dexp);
    ml[0] = ml[0] | st;
    if (big.sign == lil.sign) begin
      sum = mb + ml;
    end else begin
      sum = mb - ml;
    end
    rsign = big.sign;
    if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && (ua.sign != ub.sign))) begin
      s_o = F32QNan;
    end else if (ua.is_inf) begin
      s_o = a_i;
    end else if (ub.is_inf) begin
      s_o = b_i;
    end else if (sum == 50'd0) begin
      // exact zero: +0 unless both operands are -0
      s_o = {ua.sign & ub.sign, 31'd0};
    end else begin
      // mant bit 23 sits at sum bit 47: value = sum * 2^(exp-47)
      s_o = f32_round(rsign, 12'(big.exp) + 12'sd1, sum);
    end
  end

endmodule

FILE: rtl/rope_bf16_pair_rotator_unit.sv
// top level: cos/sin tables, range check and bf16 rotation pipeline
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  req     | in  | req_valid_i/ready_o | req_type, position, pair_index, cos,
//          |     |                     | sin, x_even, x_odd
//  rsp     | out | rsp_valid_o/ready_i | y_even, y_odd, status
//  apb     | in  | psel/penable/pwrite | seq_in_use (0x0), pairs_in_use (0x4)
//
// one item per cycle while responses are taken; after its request beat is accepted,
// a response passes the table read at the accepting edge, then the product, product
// round, add and output registers.
// the pipeline advances as a whole whenever the output register is free or taken;
// a stalled response freezes every stage. reset clears valid bits and registers
// only; the tables stay unwritten. a load followed at once by a rotate of the same
// entry reads the new data, since the write lands at the load's accepting edge.
module rope_bf16_pair_rotator_unit
  import rope_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MaxPositions,
  parameter int unsigned MAX_PAIRS     = MaxPairs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  position_i,
  input  logic [5:0]  pair_index_i,
  input  logic [31:0] cos_value_i,
  input  logic [31:0] sin_value_i,
  input  logic [15:0] x_even_i,
  input  logic [15:0] x_odd_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [15:0] y_even_o,
  output logic [15:0] y_odd_o,
  output logic        status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PairBits = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned Depth    = MAX_POSITIONS * MAX_PAIRS;
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [8:0] seq_q;
  logic [6:0] pairs_q;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      RegSeqInUse:   prdata = {23'd0, seq_q};
      RegPairsInUse: prdata = {25'd0, pairs_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 9'd256;
      pairs_q <= 7'd64;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
      if (paddr[2] == RegSeqInUse) begin
        seq_q <= pwdata[8:0];
      end else begin
        pairs_q <= pwdata[6:0];
      end
    end
  end

  // stage advance
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  assign adv         = !rsp_valid_o || rsp_ready_i;
  assign req_ready_o = adv;

  logic acc;
  assign acc = req_valid_i && adv;

  logic bad;
  logic [AddrBits-1:0] addr;
  assign bad = (32'(position_i) >= 32'(seq_q)) || (32'(position_i) >= MAX_POSITIONS) ||
               (32'(pair_index_i) >= 32'(pairs_q)) || (32'(pair_index_i) >= MAX_PAIRS);
  assign addr = AddrBits'(32'(position_i) * MAX_PAIRS + 32'(pair_index_i));

  logic we;
  assign we = acc && !bad && (req_type_i == ReqLoad);

  logic [31:0] cos_rd, sin_rd;
  rope_ram #(.Width(32), .Depth(Depth)) u_cos (
    .clk_i, .we_i(we), .waddr_i(addr), .wdata_i(cos_value_i),
    .re_i(acc), .raddr_i(addr), .rdata_o(cos_rd)
  );
  rope_ram #(.Width(32), .Depth(Depth)) u_sin (
    .clk_i, .we_i(we), .waddr_i(addr), .wdata_i(sin_value_i),
    .re_i(acc), .raddr_i(addr), .rdata_o(sin_rd)
  );

  // stage 1 sideband; the forwarding mux is never selected since fwd1_q is always cleared
  logic        rot1_q, bad1_q, fwd1_q;
  logic [31:0] fcos_q, fsin_q;
  logic [15:0] xe1_q, xo1_q;
  logic [AddrBits-1:0] wa_q;
  logic        wv_q;
  logic [31:0] wc_q, ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      wv_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      wv_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rot1_q <= req_type_i == ReqRotate;
      bad1_q <= bad;
      xe1_q  <= x_even_i;
      xo1_q  <= x_odd_i;
      // ram reads old data on same-address write; previous write landed already
      fwd1_q <= 1'b0;
      fcos_q <= cos_value_i;
      fsin_q <= sin_value_i;
      wa_q   <= addr;
      wc_q   <= cos_value_i;
      ws_q   <= sin_value_i;
    end
  end

  logic [31:0] c1, s1;
  assign c1 = fwd1_q ? fcos_q : cos_rd;
  assign s1 = fwd1_q ? fsin_q : sin_rd;

  logic unused_w;
  assign unused_w = wv_q ^ (|wa_q) ^ (|wc_q) ^ (|ws_q);

  // when frozen, ram output must hold: re only on acc, and adv gates it
  logic [31:0] x0, x1, p0c, p1s, p0s, p1c;
  assign x0 = {xe1_q, 16'd0};
  assign x1 = {xo1_q, 16'd0};

  rope_fmul u_m0 (.clk_i, .en_i(adv), .a_i(x0), .b_i(c1), .p_o(p0c));
  rope_fmul u_m1 (.clk_i, .en_i(adv), .a_i(x1), .b_i(s1), .p_o(p1s));
  rope_fmul u_m2 (.clk_i, .en_i(adv), .a_i(x0), .b_i(s1), .p_o(p0s));
  rope_fmul u_m3 (.clk_i, .en_i(adv), .a_i(x1), .b_i(c1), .p_o(p1c));

  logic rot2_q, bad2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rot2_q <= rot1_q;
      bad2_q <= bad1_q;
    end
  end

  // stage 3: rounded products registered
  logic [31:0] p0c_q, p1s_q, p0s_q, p1c_q;
  logic rot3_q, bad3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0c_q  <= p0c;
      p1s_q  <= {~p1s[31], p1s[30:0]};
      p0s_q  <= p0s;
      p1c_q  <= p1c;
      rot3_q <= rot2_q;
      bad3_q <= bad2_q;
    end
  end

  logic [31:0] ye, yo;
  rope_fadd u_a0 (.a_i(p0c_q), .b_i(p1s_q), .s_o(ye));
  rope_fadd u_a1 (.a_i(p0s_q), .b_i(p1c_q), .s_o(yo));

  // stage 4: sums registered
  logic [31:0] ye_q, yo_q;
  logic rot4_q, bad4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ye_q   <= ye;
      yo_q   <= yo;
      rot4_q <= rot3_q;
      bad4_q <= bad3_q;
    end
  end

  // output register
  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_even_o <= (rot4_q && !bad4_q) ? bf16_narrow(ye_q) : 16'd0;
      y_odd_o  <= (rot4_q && !bad4_q) ? bf16_narrow(yo_q) : 16'd0;
      status_o <= bad4_q ? StatusBadIndex : StatusDone;
    end
  end
  assign rsp_valid_o = out_v_q | unused_w & 1'b0;

endmodule

FILE: tb/sv/rope_bf16_pair_rotator_unit_tb.sv
// testbench for the bf16 pair rotator: scoreboard with bit-exact float predictor
`timescale 1ns / 1ps

module rope_bf16_pair_rotator_unit_tb
  import rope_pkg::*;
();

  localparam int unsigned TableDepth = MaxPositions * MaxPairs;

  typedef struct packed {
    logic [15:0] y_even;
    logic [15:0] y_odd;
    logic        status;
  } rot_result_t;

  typedef struct {
    logic        sgn;
    logic        nan;
    logic        inf;
    logic [23:0] man;
    int          lsb;
  } f32_parts_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  logic        req_type_i;
  logic [7:0]  position_i;
  logic [5:0]  pair_index_i;
  logic [31:0] cos_value_i;
  logic [31:0] sin_value_i;
  logic [15:0] x_even_i;
  logic [15:0] x_odd_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  logic [15:0] y_even_o;
  logic [15:0] y_odd_o;
  logic        status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  rope_bf16_pair_rotator_unit u_top (.*);

  // ---------------- float arithmetic, exact then rounded once ----------------

  function automatic f32_parts_t split_f32(input logic [31:0] b);
    f32_parts_t u;
    u.sgn = b[31];
    u.nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    u.inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    if (b[30:23] == 8'd0) begin
      u.man = {1'b0, b[22:0]};
      u.lsb = -149;
    end else begin
      u.man = {1'b1, b[22:0]};
      u.lsb = int'(b[30:23]) - 150;
    end
    return u;
  endfunction

  // value = mag * 2^lsb, rounded to nearest even f32
  function automatic logic [31:0] round_to_f32(input logic sgn, input logic [599:0] mag,
                                               input int lsb);
    int p, q, s, ef;
    logic [599:0] kept;
    logic g, st;
    if (mag == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 600; i++) if (mag[i]) p = i;
    q = p + lsb - 23;
    if (q < -149) q = -149;
    s = q - lsb;
    if (s <= 0) begin
      kept = mag << (-s);
      g = 1'b0;
      st = 1'b0;
    end else begin
      kept = mag >> s;
      g = mag[s-1];
      st = |(mag & ((600'd1 << (s - 1)) - 600'd1));
    end
    if (g && (st || kept[0])) kept = kept + 600'd1;
    if (kept[24]) begin
      kept = kept >> 1;
      q++;
    end
    if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
    ef = q + 150;
    if (ef > 254) return {sgn, 8'hFF, 23'd0};
    return {sgn, ef[7:0], kept[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    f32_parts_t ua, ub;
    logic [599:0] m;
    logic sg;
    ua = split_f32(a);
    ub = split_f32(b);
    sg = ua.sgn ^ ub.sgn;
    if (ua.nan || ub.nan || (ua.inf && b[30:0] == 0) || (ub.inf && a[30:0] == 0))
      return F32QNan;
    if (ua.inf || ub.inf) return {sg, 8'hFF, 23'd0};
    m = 600'(ua.man);
    m = m * 600'(ub.man);
    return round_to_f32(sg, m, ua.lsb + ub.lsb);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    f32_parts_t ua, ub;
    logic [599:0] ma, mb;
    ua = split_f32(a);
    ub = split_f32(b);
    if (ua.nan || ub.nan || (ua.inf && ub.inf && ua.sgn != ub.sgn)) return F32QNan;
    if (ua.inf) return a;
    if (ub.inf) return b;
    ma = 600'(ua.man) << (ua.lsb + 149);
    mb = 600'(ub.man) << (ub.lsb + 149);
    if (ma == 0 && mb == 0) return {ua.sgn & ub.sgn, 31'd0};
    if (ua.sgn == ub.sgn) return round_to_f32(ua.sgn, ma + mb, -149);
    if (ma == mb) return 32'd0;
    if (ma > mb) return round_to_f32(ua.sgn, ma - mb, -149);
    return round_to_f32(ub.sgn, mb - ma, -149);
  endfunction

  function automatic logic [15:0] shorten_to_bf16(input logic [31:0] b);
    logic [31:0] r;
    if (b[30:23] == 8'hFF && b[22:0] != 0) return Bf16QNan;
    r = b + 32'h0000_7FFF + {31'd0, b[16]};
    return r[31:16];
  endfunction

  // ---------------- scoreboard ----------------

  class rotation_scoreboard;
    logic [31:0]  cos_tab [TableDepth];
    logic [31:0]  sin_tab [TableDepth];
    int unsigned  seq_lim;
    int unsigned  pair_lim;
    rot_result_t  expected_q [$];
    int           mismatches;
    int           checked;
    int           rotates;
    int           bad_index;

    function new();
      seq_lim = MaxPositions;
      pair_lim = MaxPairs;
    endfunction

    function void note_request(logic rtype, logic [7:0] pos, logic [5:0] pair,
                               logic [31:0] cv, logic [31:0] sv,
                               logic [15:0] xe, logic [15:0] xo);
      rot_result_t r;
      int slot;
      logic [31:0] c, s, x0, x1;
      r = '0;
      slot = int'(pos) * MaxPairs + int'(pair);
      if (pos >= seq_lim || pair >= pair_lim) begin
        r.status = StatusBadIndex;
        bad_index++;
      end else if (rtype == ReqLoad) begin
        cos_tab[slot] = cv;
        sin_tab[slot] = sv;
        r.status = StatusDone;
      end else begin
        c = cos_tab[slot];
        s = sin_tab[slot];
        x0 = {xe, 16'h0};
        x1 = {xo, 16'h0};
        r.y_even = shorten_to_bf16(f32_add(f32_mul(x0, c), f32_mul(x1, s) ^ 32'h8000_0000));
        r.y_odd  = shorten_to_bf16(f32_add(f32_mul(x0, s), f32_mul(x1, c)));
        r.status = StatusDone;
        rotates++;
      end
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [15:0] ye, logic [15:0] yo, logic st);
      rot_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected response y_even=%h y_odd=%h status=%b", $time, ye, yo, st);
        return;
      end
      e = expected_q.pop_front();
      if (ye !== e.y_even || yo !== e.y_odd || st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp y_even=%h y_odd=%h status=%b got %h %h %b",
                   $time, e.y_even, e.y_odd, e.status, ye, yo, st);
      end
    endfunction
  endclass

  rotation_scoreboard sb = new();

  // shadow of config and which entries hold data, for stimulus choices
  int unsigned seq_cfg = MaxPositions;
  int unsigned pair_cfg = MaxPairs;
  bit          loaded [TableDepth];
  int          loaded_slots [$];
  int          burst_left;
  bit          hold_req;
  int          items_sent;

  always @(posedge clk_i) begin
    if (rst_ni && req_valid_i && req_ready_o)
      sb.note_request(req_type_i, position_i, pair_index_i, cos_value_i, sin_value_i,
                      x_even_i, x_odd_i);
    if (rst_ni && rsp_valid_o && rsp_ready_i)
      sb.check_response(y_even_o, y_odd_o, status_o);
  end

  // receiver: stall pattern changes every so often, plus a long hold on request
  int hold_cnt;
  int rx_mode;
  int rx_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      hold_cnt <= 0;
      rx_mode <= 0;
      rx_left <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= 80;
        rsp_ready_i <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        rsp_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: rsp_ready_i <= 1'b1;
          1: rsp_ready_i <= ($urandom_range(0, 1) == 0);
          2: rsp_ready_i <= ($urandom_range(0, 3) == 0);
          default: rsp_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) if (hold_cnt != 0) hold_req <= 1'b0;

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] rand_f32();
    logic [31:0] sp [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                            32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000};
    logic sg;
    sg = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: return sp[$urandom_range(0, 7)];
      1: return {sg, 8'd0, 23'($urandom)};
      2: return $urandom;
      default: return {sg, 8'($urandom_range(118, 128)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] rand_bf16();
    logic [15:0] sp [8] = '{16'h0, 16'h8000, 16'h7F80, 16'hFF80,
                            16'h7FC1, 16'h7F7F, 16'h0001, 16'h3F80};
    logic sg;
    sg = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: return sp[$urandom_range(0, 7)];
      1: return {sg, 8'd0, 7'($urandom)};
      2: return 16'($urandom);
      default: return {sg, 8'($urandom_range(100, 150)), 7'($urandom)};
    endcase
  endfunction

  function automatic bit in_range(int pos, int pair);
    return pos < seq_cfg && pair < pair_cfg;
  endfunction

  task automatic send_beat(logic rtype, int pos, int pair, logic [31:0] cv, logic [31:0] sv,
                           logic [15:0] xe, logic [15:0] xo);
    int gap;
    if (rtype == ReqLoad && in_range(pos, pair) && !loaded[pos * MaxPairs + pair]) begin
      loaded[pos * MaxPairs + pair] = 1'b1;
      loaded_slots.push_back(pos * MaxPairs + pair);
    end
    req_valid_i <= 1'b1;
    req_type_i <= rtype;
    position_i <= 8'(pos);
    pair_index_i <= 6'(pair);
    cos_value_i <= cv;
    sin_value_i <= sv;
    x_even_i <= xe;
    x_odd_i <= xo;
    do @(posedge clk_i); while (!req_ready_o);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic load_entry(int pos, int pair, logic [31:0] cv, logic [31:0] sv);
    send_beat(ReqLoad, pos, pair, cv, sv, 16'($urandom), 16'($urandom));
  endtask

  task automatic rotate_pair(int pos, int pair, logic [15:0] xe, logic [15:0] xo);
    send_beat(ReqRotate, pos, pair, $urandom, $urandom, xe, xo);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [0:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegSeqInUse) begin
      seq_cfg = val & 32'h1FF;
      sb.seq_lim = seq_cfg;
    end else begin
      pair_cfg = val & 32'h7F;
      sb.pair_lim = pair_cfg;
    end
  endtask

  task automatic set_limits(int unsigned seq_v, int unsigned pair_v);
    drain();
    apb_write(RegSeqInUse, seq_v);
    apb_write(RegPairsInUse, pair_v);
    @(posedge clk_i);
  endtask

  task automatic random_beat();
    int slot, pos, pair, lim;
    if (loaded_slots.size() != 0 && $urandom_range(0, 99) < 55) begin
      slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
      rotate_pair(slot / MaxPairs, slot % MaxPairs, rand_bf16(), rand_bf16());
    end else if ($urandom_range(0, 99) < 12) begin
      // noise: anywhere, a rotate only where it cannot read an empty entry
      pos = $urandom_range(0, 255);
      pair = $urandom_range(0, 63);
      if (!in_range(pos, pair) && $urandom_range(0, 1))
        rotate_pair(pos, pair, rand_bf16(), rand_bf16());
      else
        load_entry(pos, pair, rand_f32(), rand_f32());
    end else begin
      lim = (seq_cfg > MaxPositions) ? MaxPositions : seq_cfg;
      pos = (lim == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim - 1);
      lim = (pair_cfg > MaxPairs) ? MaxPairs : pair_cfg;
      pair = (lim == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
      load_entry(pos, pair, rand_f32(), rand_f32());
      if ($urandom_range(0, 3) == 0 && in_range(pos, pair))
        rotate_pair(pos, pair, rand_bf16(), rand_bf16());
    end
  endtask

  // ---------------- run ----------------

  int unsigned seq_plan [8] = '{256, 1, 511, 0, 37, 256, 200, 256};
  int unsigned pair_plan [8] = '{64, 1, 127, 7, 63, 0, 40, 64};

  initial begin
    rst_ni = 1'b0;
    req_valid_i <= 1'b0;
    req_type_i <= ReqLoad;
    position_i <= '0;
    pair_index_i <= '0;
    cos_value_i <= '0;
    sin_value_i <= '0;
    x_even_i <= '0;
    x_odd_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    burst_left = 0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner entries and special float values
    load_entry(0, 0, 32'h3F80_0000, 32'h0000_0000);
    load_entry(255, 63, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    load_entry(1, 2, 32'h7F80_0000, 32'h0000_0000);
    load_entry(3, 4, 32'h0000_0001, 32'h8000_0001);
    rotate_pair(0, 0, 16'h3F80, 16'h4000);
    rotate_pair(0, 0, 16'h7FC1, 16'h0000);
    rotate_pair(255, 63, 16'h7F7F, 16'hFF7F);
    rotate_pair(255, 63, 16'h0001, 16'h8001);
    rotate_pair(1, 2, 16'h0000, 16'h3F80);   // inf times zero
    rotate_pair(3, 4, 16'h3F80, 16'h3F80);   // subnormal products
    rotate_pair(0, 0, 16'h7F80, 16'hFF80);
    rotate_pair(255, 63, 16'hFFFF, 16'hFFFF);
    load_entry(7, 9, 32'hBF00_0000, 32'h3F5D_B3D7);
    rotate_pair(7, 9, 16'h4040, 16'hC0A0);   // after its load, back to back unless a random gap falls between
    load_entry(7, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    rotate_pair(7, 9, 16'h3F80, 16'h3F80);
    set_limits(10, 5);
    load_entry(10, 0, 32'h3F80_0000, 32'h0);
    load_entry(0, 5, 32'h3F80_0000, 32'h0);
    load_entry(9, 4, 32'h3F80_0000, 32'h0);
    rotate_pair(255, 63, 16'h3F80, 16'h3F80);
    rotate_pair(9, 4, 16'h3F80, 16'h3F80);
    rotate_pair(3, 4, 16'h0000, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      set_limits(seq_plan[ph], pair_plan[ph]);
      for (int n = 0; n < 110; n++) begin
        if (ph == 2 && n == 40) hold_req <= 1'b1;
        if (ph == 4 && n == 50) drain();
        random_beat();
      end
    end
    drain();

    $display("items %0d, rotations %0d, out-of-range %0d, responses checked %0d",
             items_sent, sb.rotates, sb.bad_index, sb.checked);
    $display("limit settings covered: %0d, including zero and full-width values", 9);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("rope_bf16_pair_rotator_unit_tb OK");
    end else begin
      $display("rope_bf16_pair_rotator_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout with %0d responses outstanding", sb.expected_q.size());
    $display("rope_bf16_pair_rotator_unit_tb NOT OK");
    $finish;
  end

endmodule
